/* rtl/tetration_mod_assert.svh */
// ----------------------------------------------------------------------------
// tetration_mod_assert.svh
// assertion macros for the tetration modulo block
// ----------------------------------------------------------------------------
`ifndef TETRATION_MOD_ASSERT_SVH
`define TETRATION_MOD_ASSERT_SVH

`ifndef SYNTH
`define TETM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("assertion failed");
`define TETM_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error("assertion failed");
`else
`define TETM_ASSERT(lbl, prop)
`define TETM_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

/* rtl/tetm_pkg.sv */
// ----------------------------------------------------------------------------
// tetm_pkg
// shared types and constants for the tetration modulo block
// ----------------------------------------------------------------------------
package tetm_pkg;

  localparam int FIELD_W = 32;
  localparam int S_DATA_W = 3 * FIELD_W;
  localparam int M_DATA_W = FIELD_W;

  typedef enum logic [5:0] {
    C_NOP, C_LOAD, C_ZERO_R, C_CH_INIT, C_TOT_INIT, C_DIV_NP, C_P_INC, C_SAVE_Q,
    C_DIV_TRP, C_MUL_TRP, C_TR_SET, C_N_Q, C_DIV_TRN, C_MUL_TRN, C_CH_PUSH,
    C_PUSH_MUL, C_R_ONE, C_DIV_ACV, C_R_REM, C_T_PAR, C_CT_INIT, C_CT_INC,
    C_T_ONE, C_T_ZERO, C_CP_INIT, C_MUL_CP, C_CP_STEP, C_T_CP, C_RD_HI, C_RD_LO,
    C_SET_E, C_DIV_AMD, C_PW_INIT, C_MUL_RX, C_R_MUL, C_MUL_XX, C_X_MUL,
    C_LV_DEC, C_OUT
  } dp_cmd_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_CH_TEST, S_T_DIV, S_T_DIVW, S_T_RDIV, S_T_RDIVW, S_T_RMULW,
    S_T_STRIP, S_T_STRIPW, S_T_FIN, S_T_FDIVW, S_T_FMULW, S_TOP, S_TOP_W, S_CT,
    S_CT_LOOP, S_CP, S_CP_MUL, S_CP_MULW, S_CP_CHK, S_DESC, S_RD_LO, S_SET_E,
    S_PW_DIV, S_PW_DIVW, S_PW_LOOP, S_PW_RW, S_PW_SQ, S_PW_XW, S_LV_DEC, S_FINISH
  } state_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic m_zero;
    logic cv_one;
    logic h_gt;
    logic lv_max;
    logic h_zero;
    logic q_lt_p;
    logic rem_zero;
    logic n_gt1;
    logic a_zero;
    logic a_one;
    logic t_zero;
    logic ct_done;
    logic cp_sat;
    logic kc_done;
    logic lv_zero;
    logic es_zero;
    logic es_lsb;
  } dp_status_t;

endpackage

/* rtl/tetm_div.sv */
// ----------------------------------------------------------------------------
// tetm_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tetm_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  dv;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;

  assign trial = {rem, quo[W-1]};
  assign diff  = trial - {1'b0, dv};
  assign ge    = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        quo  <= dividend;
        dv   <= divisor;
        cnt  <= CW'(W);
      end else if (busy) begin
        rem <= ge ? diff[W-1:0] : trial[W-1:0];
        quo <= {quo[W-2:0], ge};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/tetm_mul.sv */
// ----------------------------------------------------------------------------
// tetm_mul
// serial multiplier, modular or saturating at 2^W, msb first
// ----------------------------------------------------------------------------
module tetm_mul #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         sat,
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  input  logic [W-1:0] md,
  output logic         done,
  output logic [W:0]   prod
);

  localparam int CW = $clog2(W + 1);
  localparam logic [W+1:0] SAT_LIM = (W+2)'(1) << W;

  logic          busy;
  logic          phase;
  logic          satr;
  logic [CW-1:0] cnt;
  logic [W-1:0]  xr;
  logic [W-1:0]  ys;
  logic [W-1:0]  mr;
  logic [W+1:0]  lim;
  logic [W+1:0]  v;
  logic [W+1:0]  red;

  assign lim  = satr ? SAT_LIM : {2'b00, mr};
  assign v    = phase ? ({1'b0, prod} + {2'b00, xr}) : {prod, 1'b0};
  assign red  = (v >= lim) ? (satr ? lim : v - lim) : v;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        prod  <= '0;
        xr    <= x;
        ys    <= y;
        mr    <= md;
        satr  <= sat;
        cnt   <= CW'(W);
      end else if (busy) begin
        prod <= red[W:0];
        if (!phase && ys[W-1]) begin
          phase <= 1'b1;
        end else begin
          phase <= 1'b0;
          ys    <= ys << 1;
          cnt   <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

endmodule

/* rtl/tetm_dp.sv */
// ----------------------------------------------------------------------------
// tetm_dp
// datapath: operand registers, totient chain memory, divider and multiplier
// ----------------------------------------------------------------------------
module tetm_dp #(
  parameter int W = 32,
  parameter int D = 66
) (
  input  logic                      clk,
  input  logic                      rst,
  input  tetm_pkg::dp_cmd_t         cmd,
  input  logic [tetm_pkg::S_DATA_W-1:0] s_tdata,
  output tetm_pkg::dp_status_t      st,
  output logic [tetm_pkg::M_DATA_W-1:0] m_tdata
);

  localparam int LVW = $clog2(D);
  localparam logic [W:0] SAT = (W+1)'(1) << W;

  logic [W-1:0]   a, h, m, cv, n, p, tr, qs, r, ph, md, xb;
  logic [W:0]     t, cp, kc, es;
  logic [3:0]     ct;
  logic [LVW-1:0] lv;
  logic [W-1:0]   s_len;

  logic [W-1:0]   mem [D];
  logic [W-1:0]   rdata;
  logic           wr_en;
  logic [LVW-1:0] wr_addr, rd_addr;
  logic [W-1:0]   wr_data;

  logic           div_start, div_done;
  logic [W-1:0]   div_a, div_b, div_q, div_r;
  logic           mul_start, mul_sat, mul_done;
  logic [W-1:0]   mul_x, mul_y;
  logic [W:0]     mul_prod;

  assign s_len = h - W'(lv);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = lv + LVW'(1);
    wr_data = tr;
    case (cmd)
      tetm_pkg::C_CH_INIT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = m;
      end
      tetm_pkg::C_CH_PUSH: wr_en = 1'b1;
      tetm_pkg::C_PUSH_MUL: begin
        wr_en   = 1'b1;
        wr_data = mul_prod[W-1:0];
      end
      default: ;
    endcase
  end

  assign rd_addr = (cmd == tetm_pkg::C_RD_HI) ? lv : lv - LVW'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_comb begin
    div_start = 1'b1;
    div_a     = n;
    div_b     = p;
    case (cmd)
      tetm_pkg::C_DIV_NP: ;
      tetm_pkg::C_DIV_TRP: div_a = tr;
      tetm_pkg::C_DIV_TRN: begin
        div_a = tr;
        div_b = n;
      end
      tetm_pkg::C_DIV_ACV: begin
        div_a = a;
        div_b = cv;
      end
      tetm_pkg::C_DIV_AMD: begin
        div_a = a;
        div_b = md;
      end
      default: div_start = 1'b0;
    endcase
  end

  always_comb begin
    mul_start = 1'b1;
    mul_sat   = 1'b1;
    mul_x     = div_q;
    mul_y     = p - W'(1);
    case (cmd)
      tetm_pkg::C_MUL_TRP: ;
      tetm_pkg::C_MUL_TRN: mul_y = n - W'(1);
      tetm_pkg::C_MUL_CP: begin
        mul_x = a;
        mul_y = cp[W-1:0];
      end
      tetm_pkg::C_MUL_RX: begin
        mul_sat = 1'b0;
        mul_x   = xb;
        mul_y   = r;
      end
      tetm_pkg::C_MUL_XX: begin
        mul_sat = 1'b0;
        mul_x   = xb;
        mul_y   = xb;
      end
      default: mul_start = 1'b0;
    endcase
  end

  tetm_div #(.W(W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (div_q),
    .rem      (div_r)
  );

  tetm_mul #(.W(W)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .sat   (mul_sat),
    .x     (mul_x),
    .y     (mul_y),
    .md    (md),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_ff @(posedge clk) begin
    case (cmd)
      tetm_pkg::C_LOAD: begin
        a <= W'(s_tdata[tetm_pkg::FIELD_W-1:0]);
        h <= W'(s_tdata[2*tetm_pkg::FIELD_W-1:tetm_pkg::FIELD_W]);
        m <= W'(s_tdata[3*tetm_pkg::FIELD_W-1:2*tetm_pkg::FIELD_W]);
      end
      tetm_pkg::C_ZERO_R: r <= '0;
      tetm_pkg::C_CH_INIT: begin
        lv <= '0;
        cv <= m;
      end
      tetm_pkg::C_TOT_INIT: begin
        n  <= cv;
        tr <= cv;
        p  <= W'(2);
      end
      tetm_pkg::C_P_INC: p <= p + W'(1);
      tetm_pkg::C_SAVE_Q: qs <= div_q;
      tetm_pkg::C_TR_SET: begin
        tr <= mul_prod[W-1:0];
        n  <= qs;
      end
      tetm_pkg::C_N_Q: n <= div_q;
      tetm_pkg::C_CH_PUSH: begin
        lv <= lv + LVW'(1);
        cv <= tr;
      end
      tetm_pkg::C_PUSH_MUL: begin
        lv <= lv + LVW'(1);
        cv <= mul_prod[W-1:0];
      end
      tetm_pkg::C_R_ONE: r <= W'(1);
      tetm_pkg::C_R_REM: r <= div_r;
      tetm_pkg::C_T_PAR: t <= s_len[0] ? '0 : (W+1)'(1);
      tetm_pkg::C_CT_INIT: begin
        ct <= '0;
        t  <= (W+1)'(1);
      end
      tetm_pkg::C_CT_INC: ct <= ct + 4'd1;
      tetm_pkg::C_T_ONE: t <= (W+1)'(1);
      tetm_pkg::C_T_ZERO: t <= '0;
      tetm_pkg::C_CP_INIT: begin
        cp <= (W+1)'(1);
        kc <= '0;
      end
      tetm_pkg::C_CP_STEP: begin
        cp <= mul_prod;
        kc <= kc + (W+1)'(1);
      end
      tetm_pkg::C_T_CP: t <= cp;
      tetm_pkg::C_RD_LO: ph <= rdata;
      tetm_pkg::C_SET_E: begin
        md <= rdata;
        es <= {1'b0, r} + ((t >= {1'b0, ph}) ? {1'b0, ph} : '0);
      end
      tetm_pkg::C_PW_INIT: begin
        xb <= div_r;
        r  <= (md == W'(1)) ? '0 : W'(1);
      end
      tetm_pkg::C_R_MUL: r <= mul_prod[W-1:0];
      tetm_pkg::C_X_MUL: begin
        xb <= mul_prod[W-1:0];
        es <= es >> 1;
      end
      tetm_pkg::C_LV_DEC: lv <= lv - LVW'(1);
      tetm_pkg::C_OUT: m_tdata <= tetm_pkg::M_DATA_W'(r);
      default: ;
    endcase
  end

  always_comb begin
    st.div_done = div_done;
    st.mul_done = mul_done;
    st.m_zero   = (m == '0);
    st.cv_one   = (cv == W'(1));
    st.h_gt     = ((W+1)'(h) > ((W+1)'(lv) + (W+1)'(1)));
    st.lv_max   = (lv == LVW'(D - 1));
    st.h_zero   = (h == '0);
    st.q_lt_p   = (div_q < p);
    st.rem_zero = (div_r == '0);
    st.n_gt1    = (n > W'(1));
    st.a_zero   = (a == '0);
    st.a_one    = (a == W'(1));
    st.t_zero   = (t == '0);
    st.ct_done  = (ct == 4'd8) || ((s_len < W'(8)) && (ct == s_len[3:0]));
    st.cp_sat   = (cp == SAT);
    st.kc_done  = (kc == t);
    st.lv_zero  = (lv == '0);
    st.es_zero  = (es == '0);
    st.es_lsb   = es[0];
  end

endmodule

/* rtl/tetm_ctrl.sv */
// ----------------------------------------------------------------------------
// tetm_ctrl
// sequencer for chain build, tower evaluation and result handoff
// ----------------------------------------------------------------------------
`include "tetration_mod_assert.svh"

module tetm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  tetm_pkg::dp_status_t st,
  output tetm_pkg::dp_cmd_t    cmd
);

  tetm_pkg::state_t state, state_next;
  logic ret_desc, ret_desc_next;
  logic out_valid;
  tetm_pkg::state_t ret_state;

  assign m_tvalid  = out_valid;
  assign ret_state = ret_desc ? tetm_pkg::S_LV_DEC : tetm_pkg::S_CT_LOOP;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tetm_pkg::S_IDLE;
      ret_desc  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      ret_desc <= ret_desc_next;
      if (cmd == tetm_pkg::C_OUT) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next    = state;
    ret_desc_next = ret_desc;
    cmd           = tetm_pkg::C_NOP;
    s_tready      = 1'b0;
    case (state)
      tetm_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd        = tetm_pkg::C_LOAD;
          state_next = tetm_pkg::S_CHK;
        end
      end
      tetm_pkg::S_CHK: begin
        if (st.m_zero) begin
          cmd        = tetm_pkg::C_ZERO_R;
          state_next = tetm_pkg::S_FINISH;
        end else begin
          cmd        = tetm_pkg::C_CH_INIT;
          state_next = tetm_pkg::S_CH_TEST;
        end
      end
      tetm_pkg::S_CH_TEST: begin
        if (!st.cv_one && st.h_gt && !st.lv_max) begin
          cmd        = tetm_pkg::C_TOT_INIT;
          state_next = tetm_pkg::S_T_DIV;
        end else begin
          state_next = tetm_pkg::S_TOP;
        end
      end
      tetm_pkg::S_T_DIV: begin
        cmd        = tetm_pkg::C_DIV_NP;
        state_next = tetm_pkg::S_T_DIVW;
      end
      tetm_pkg::S_T_DIVW: begin
        if (st.div_done) begin
          if (st.q_lt_p) begin
            state_next = tetm_pkg::S_T_FIN;
          end else if (!st.rem_zero) begin
            cmd        = tetm_pkg::C_P_INC;
            state_next = tetm_pkg::S_T_DIV;
          end else begin
            cmd        = tetm_pkg::C_SAVE_Q;
            state_next = tetm_pkg::S_T_RDIV;
          end
        end
      end
      tetm_pkg::S_T_RDIV: begin
        cmd        = tetm_pkg::C_DIV_TRP;
        state_next = tetm_pkg::S_T_RDIVW;
      end
      tetm_pkg::S_T_RDIVW: begin
        if (st.div_done) begin
          cmd        = tetm_pkg::C_MUL_TRP;
          state_next = tetm_pkg::S_T_RMULW;
        end
      end
      tetm_pkg::S_T_RMULW: begin
        if (st.mul_done) begin
          cmd        = tetm_pkg::C_TR_SET;
          state_next = tetm_pkg::S_T_STRIP;
        end
      end
      tetm_pkg::S_T_STRIP: begin
        cmd        = tetm_pkg::C_DIV_NP;
        state_next = tetm_pkg::S_T_STRIPW;
      end
      tetm_pkg::S_T_STRIPW: begin
        if (st.div_done) begin
          if (st.rem_zero) begin
            cmd        = tetm_pkg::C_N_Q;
            state_next = tetm_pkg::S_T_STRIP;
          end else begin
            cmd        = tetm_pkg::C_P_INC;
            state_next = tetm_pkg::S_T_DIV;
          end
        end
      end
      tetm_pkg::S_T_FIN: begin
        if (st.n_gt1) begin
          cmd        = tetm_pkg::C_DIV_TRN;
          state_next = tetm_pkg::S_T_FDIVW;
        end else begin
          cmd        = tetm_pkg::C_CH_PUSH;
          state_next = tetm_pkg::S_CH_TEST;
        end
      end
      tetm_pkg::S_T_FDIVW: begin
        if (st.div_done) begin
          cmd        = tetm_pkg::C_MUL_TRN;
          state_next = tetm_pkg::S_T_FMULW;
        end
      end
      tetm_pkg::S_T_FMULW: begin
        if (st.mul_done) begin
          cmd        = tetm_pkg::C_PUSH_MUL;
          state_next = tetm_pkg::S_CH_TEST;
        end
      end
      tetm_pkg::S_TOP: begin
        if (st.cv_one || st.h_gt) begin
          cmd        = tetm_pkg::C_ZERO_R;
          state_next = tetm_pkg::S_CT;
        end else if (st.h_zero) begin
          cmd        = tetm_pkg::C_R_ONE;
          state_next = tetm_pkg::S_CT;
        end else begin
          cmd        = tetm_pkg::C_DIV_ACV;
          state_next = tetm_pkg::S_TOP_W;
        end
      end
      tetm_pkg::S_TOP_W: begin
        if (st.div_done) begin
          cmd        = tetm_pkg::C_R_REM;
          state_next = tetm_pkg::S_CT;
        end
      end
      tetm_pkg::S_CT: begin
        if (st.a_zero) begin
          cmd        = tetm_pkg::C_T_PAR;
          state_next = tetm_pkg::S_DESC;
        end else begin
          cmd        = tetm_pkg::C_CT_INIT;
          state_next = tetm_pkg::S_CT_LOOP;
        end
      end
      tetm_pkg::S_CT_LOOP: begin
        if (st.ct_done) begin
          state_next = tetm_pkg::S_DESC;
        end else begin
          cmd           = tetm_pkg::C_CT_INC;
          ret_desc_next = 1'b0;
          state_next    = tetm_pkg::S_CP;
        end
      end
      tetm_pkg::S_CP: begin
        if (st.t_zero || (st.a_one && !st.a_zero)) begin
          cmd        = tetm_pkg::C_T_ONE;
          state_next = ret_state;
        end else if (st.a_zero) begin
          cmd        = tetm_pkg::C_T_ZERO;
          state_next = ret_state;
        end else begin
          cmd        = tetm_pkg::C_CP_INIT;
          state_next = tetm_pkg::S_CP_MUL;
        end
      end
      tetm_pkg::S_CP_MUL: begin
        cmd        = tetm_pkg::C_MUL_CP;
        state_next = tetm_pkg::S_CP_MULW;
      end
      tetm_pkg::S_CP_MULW: begin
        if (st.mul_done) begin
          cmd        = tetm_pkg::C_CP_STEP;
          state_next = tetm_pkg::S_CP_CHK;
        end
      end
      tetm_pkg::S_CP_CHK: begin
        if (st.cp_sat || st.kc_done) begin
          cmd        = tetm_pkg::C_T_CP;
          state_next = ret_state;
        end else begin
          state_next = tetm_pkg::S_CP_MUL;
        end
      end
      tetm_pkg::S_DESC: begin
        if (st.lv_zero) begin
          state_next = tetm_pkg::S_FINISH;
        end else begin
          cmd        = tetm_pkg::C_RD_HI;
          state_next = tetm_pkg::S_RD_LO;
        end
      end
      tetm_pkg::S_RD_LO: begin
        cmd        = tetm_pkg::C_RD_LO;
        state_next = tetm_pkg::S_SET_E;
      end
      tetm_pkg::S_SET_E: begin
        cmd        = tetm_pkg::C_SET_E;
        state_next = tetm_pkg::S_PW_DIV;
      end
      tetm_pkg::S_PW_DIV: begin
        cmd        = tetm_pkg::C_DIV_AMD;
        state_next = tetm_pkg::S_PW_DIVW;
      end
      tetm_pkg::S_PW_DIVW: begin
        if (st.div_done) begin
          cmd        = tetm_pkg::C_PW_INIT;
          state_next = tetm_pkg::S_PW_LOOP;
        end
      end
      tetm_pkg::S_PW_LOOP: begin
        if (st.es_zero) begin
          ret_desc_next = 1'b1;
          state_next    = tetm_pkg::S_CP;
        end else if (st.es_lsb) begin
          cmd        = tetm_pkg::C_MUL_RX;
          state_next = tetm_pkg::S_PW_RW;
        end else begin
          cmd        = tetm_pkg::C_MUL_XX;
          state_next = tetm_pkg::S_PW_XW;
        end
      end
      tetm_pkg::S_PW_RW: begin
        if (st.mul_done) begin
          cmd        = tetm_pkg::C_R_MUL;
          state_next = tetm_pkg::S_PW_SQ;
        end
      end
      tetm_pkg::S_PW_SQ: begin
        cmd        = tetm_pkg::C_MUL_XX;
        state_next = tetm_pkg::S_PW_XW;
      end
      tetm_pkg::S_PW_XW: begin
        if (st.mul_done) begin
          cmd        = tetm_pkg::C_X_MUL;
          state_next = tetm_pkg::S_PW_LOOP;
        end
      end
      tetm_pkg::S_LV_DEC: begin
        cmd        = tetm_pkg::C_LV_DEC;
        state_next = tetm_pkg::S_DESC;
      end
      tetm_pkg::S_FINISH: begin
        if (!out_valid || m_tready) begin
          cmd        = tetm_pkg::C_OUT;
          state_next = tetm_pkg::S_IDLE;
        end
      end
      default: state_next = tetm_pkg::S_IDLE;
    endcase
  end

  `TETM_ASSERT(a_out_free, (cmd == tetm_pkg::C_OUT) |-> (!out_valid || m_tready))
  `TETM_ASSERT_NEXT(a_out_set, cmd == tetm_pkg::C_OUT, out_valid)
  `TETM_ASSERT_NEXT(a_accept_chk, s_tvalid && s_tready, state == tetm_pkg::S_CHK)
  `TETM_ASSERT(a_dec_in_desc, (state == tetm_pkg::S_LV_DEC) |-> ret_desc)

endmodule

/* rtl/tetration_mod.sv */
// ----------------------------------------------------------------------------
// tetration_mod
// power tower of a base and height reduced by a modulus, via a totient chain
// ----------------------------------------------------------------------------
//   channel   dir  fields (lsb first)
//   s_*       in   base[31:0], height[63:32], modulus[95:64]
//   m_*       out  residue[31:0]
//
// one request at a time; chain build by trial division, one divider pass per
// candidate factor, dominates: up to about 2^(WIDTH/2) passes for a prime
// modulus, typically far fewer. each tower level runs the serial multiplier
// for every exponent bit.
// synchronous reset returns the sequencer to idle with no result pending.
// a new request is taken while a result waits; the next result waits for it.
// ----------------------------------------------------------------------------
module tetration_mod #(
  parameter int WIDTH       = 32,
  parameter int CHAIN_DEPTH = 66
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tetm_pkg::S_DATA_W-1:0] s_tdata,  // base, height, modulus
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tetm_pkg::M_DATA_W-1:0] m_tdata   // residue
);

  tetm_pkg::dp_cmd_t    cmd;
  tetm_pkg::dp_status_t st;

  tetm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .st       (st),
    .cmd      (cmd)
  );

  tetm_dp #(.W(WIDTH), .D(CHAIN_DEPTH)) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .s_tdata (s_tdata),
    .st      (st),
    .m_tdata (m_tdata)
  );

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// checks tetration_mod: power towers reduced by a modulus, predicted per
// request and compared in order against every residue the block returns
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned SAT = 64'd1 << 32;
  localparam int DEPTH = 66;
  localparam longint LIMIT = 100000000;
  localparam int N_RAND = 80;

  // min(x^t, SAT), 0^0 = 1
  function automatic longint unsigned sat_pow(longint unsigned x, longint unsigned t);
    longint unsigned r;
    longint unsigned k;
    r = 1;
    if (t == 0) return 1;
    if (x == 0) return 0;
    if (x == 1) return 1;
    for (k = 0; k < t; k++) begin
      if (r > SAT / x) return SAT;
      r = r * x;
      if (r >= SAT) return SAT;
    end
    return r;
  endfunction

  function automatic longint unsigned phi(longint unsigned n);
    longint unsigned r;
    longint unsigned p;
    r = n;
    if (n == 0) return 0;
    for (p = 2; p <= n / p; p++) begin
      if (n % p == 0) begin
        r = r / p * (p - 1);
        while (n % p == 0) n = n / p;
      end
    end
    if (n > 1) r = r / n * (n - 1);
    return r;
  endfunction

  function automatic longint unsigned exp_mod(longint unsigned x, longint unsigned e,
                                              longint unsigned m);
    longint unsigned r;
    r = 1 % m;
    x = x % m;
    while (e != 0) begin
      if (e[0]) r = (r * x) % m;
      x = (x * x) % m;
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic logic [31:0] tower_residue(logic [31:0] a_in, logic [31:0] h_in,
                                                logic [31:0] m_in);
    longint unsigned chain [DEPTH];
    longint unsigned a, h, top, r, t, e, k, n;
    longint unsigned lv;
    a = a_in;
    h = h_in;
    lv = 0;
    if (m_in == 0) return 0;
    chain[0] = m_in;
    while (chain[lv] != 1 && h > lv + 1 && lv < DEPTH - 1) begin
      chain[lv + 1] = phi(chain[lv]);
      lv++;
    end
    top = chain[lv];
    if (top == 1 || h > lv + 1) r = 0;
    else if (h == lv) r = 1 % top;
    else r = a % top;
    if (a == 0) t = ((h - lv) & 1) ? 0 : 1;
    else begin
      t = 1;
      n = (h - lv) < 8 ? (h - lv) : 8;
      for (k = 0; k < n; k++) t = sat_pow(a, t);
    end
    while (lv > 0) begin
      e = r;
      if (t >= chain[lv]) e = e + chain[lv];
      r = exp_mod(a, e, chain[lv - 1]);
      t = sat_pow(a, t);
      lv--;
    end
    return r[31:0];
  endfunction

  class residue_board;
    logic [31:0] awaited [$];
    int errors;

    function void note_request(logic [31:0] a, logic [31:0] h, logic [31:0] m);
      awaited.push_back(tower_residue(a, h, m));
    endfunction

    function void check_residue(logic [31:0] got);
      logic [31:0] want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected residue %h", $time, got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (want !== got) begin
        $display("%0t: residue expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [95:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [31:0] m_tdata;

  residue_board board = new();
  bit quiet = 0;
  bit hold_req = 0;
  longint cycles = 0;

  tetration_mod dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_residue(m_tdata);
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        stall = 400000;
      end else if (stall == 0 && !quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 9);
      end
      if (stall > 0) begin
        stall--;
        m_tready <= 0;
      end else begin
        m_tready <= 1;
      end
    end
  end

  task automatic send(logic [31:0] a, logic [31:0] h, logic [31:0] m);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {m, h, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_request(a, h, m);
  endtask

  task automatic send_random();
    logic [31:0] a, h, m;
    int sel;
    a = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 5);
    h = $urandom_range(0, 9) < 6 ? $urandom_range(0, 8) : $urandom;
    sel = $urandom_range(0, 9);
    if (sel < 7) m = $urandom_range(1, 4095);
    else if (sel < 9) m = $urandom_range(1, 4095) << $urandom_range(0, 31);
    else m = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1 << $urandom_range(0, 31);
    if (m == 0) m = 1;
    send(a, h, m);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (board.awaited.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // modulus one, height zero/one, zero base, extremes
    send(32'd0, 32'd0, 32'd1);
    send(32'd5, 32'd3, 32'd1);
    send(32'd0, 32'd0, 32'd7);
    send(32'd0, 32'd1, 32'd7);
    send(32'd0, 32'd2, 32'd7);
    send(32'd0, 32'd3, 32'd1000);
    send(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(32'd2, 32'd0, 32'd100);
    send(32'd2, 32'd1, 32'd100);
    send(32'd2, 32'd2, 32'd100);
    send(32'd2, 32'd3, 32'd100);
    send(32'd2, 32'd4, 32'd100);
    send(32'd3, 32'd2, 32'd12);
    send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
    send(32'd7, 32'd5, 32'h8000_0000);
    send(32'd2, 32'hFFFF_FFFF, 32'h8000_0000);
    send(32'd10, 32'd3, 32'hFFFF_FFFF);
    send(32'hAAAA_5555, 32'h5555_AAAA, 32'd4095);

    // sender pauses for everything to return
    drain();

    for (int i = 0; i < N_RAND; i++) begin
      if (i == 30) hold_req = 1;
      if (i == 50) drain();
      if (i == N_RAND - 20) quiet = 1;
      send_random();
    end
    s_tvalid <= 0;

    while (board.awaited.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
